@@ src/trapezoid_transfer_function_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the trapezoid transfer function block.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_TRANSFER_FUNCTION_ASSERT_SVH
`define TRAPEZOID_TRANSFER_FUNCTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTF_ASSERT_NOW(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (con)) \
    else $error("ttf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTF_ASSERT_NEXT(lbl, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (con)) \
    else $error("ttf: next-cycle check failed");

// The condition must hold in the cycle that follows a reset cycle.
`define TTF_ASSERT_AFTER_RESET(lbl, con) \
  lbl: assert property (@(posedge clk) rst |=> (con)) \
    else $error("ttf: post-reset check failed");

`endif

@@ src/ttf_pkg.sv @@
// ----------------------------------------------------------------------------
// ttf_pkg
// Types and constants of the trapezoid transfer function pipeline.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int POS_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int DATA_W     = 8;
  localparam int REG_IDX_W  = 3;
  localparam int PROD_W     = POS_W + DATA_W;
  // Quotient bits resolved by each divider stage.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = LEVEL_W / DIV_STEPS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START      = 3'd0,
    REG_RISE_END   = 3'd1,
    REG_FALL_START = 3'd2,
    REG_END        = 3'd3,
    REG_HEIGHT     = 3'd4
  } ttf_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  rise_end_pos;
    logic [POS_W-1:0]  fall_start_pos;
    logic [POS_W-1:0]  end_pos;
    logic [DATA_W-1:0] peak_height;
  } ttf_cfg_t;

  // Fraction num/den of the height; den is never zero.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] num;
    logic [POS_W-1:0] den;
  } ttf_frac_t;

  // Divider word: upper half is the partial remainder, lower half holds the
  // dividend bits still to go and the quotient bits already found.
  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] work;
    logic [POS_W-1:0]  den;
  } ttf_div_t;

endpackage

@@ src/ttf_pos_if.sv @@
// ----------------------------------------------------------------------------
// ttf_pos_if
// Valid/ready channel that carries one table position per beat.
// ----------------------------------------------------------------------------
interface ttf_pos_if
  import ttf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

@@ src/ttf_level_if.sv @@
// ----------------------------------------------------------------------------
// ttf_level_if
// Valid/ready channel that carries one transfer function level per beat.
// ----------------------------------------------------------------------------
interface ttf_level_if
  import ttf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

@@ src/ttf_classify.sv @@
// ----------------------------------------------------------------------------
// ttf_classify
// First stage: finds the region of the position and forms the fraction.
// ----------------------------------------------------------------------------
module ttf_classify
  import ttf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid,
  input  logic [POS_W-1:0] position,
  input  ttf_cfg_t         cfg,
  output ttf_frac_t        frac
);

  localparam logic [POS_W-1:0] ONE  = POS_W'(1);
  localparam logic [POS_W-1:0] ZERO = '0;

  logic [POS_W-1:0] num_next;
  logic [POS_W-1:0] den_next;

  // The plateau and the degenerate edges use 1/1, which yields the height;
  // outside the trapezoid 0/1 yields zero.
  always_comb begin
    num_next = ONE;
    den_next = ONE;
    if (position > cfg.end_pos || position < cfg.start_pos) begin
      num_next = ZERO;
    end else if (position < cfg.rise_end_pos) begin
      if (cfg.rise_end_pos > cfg.start_pos) begin
        num_next = position - cfg.start_pos;
        den_next = cfg.rise_end_pos - cfg.start_pos;
      end
    end else if (position > cfg.fall_start_pos) begin
      if (cfg.end_pos > cfg.fall_start_pos) begin
        num_next = cfg.end_pos - position;
        den_next = cfg.end_pos - cfg.fall_start_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac.valid <= 1'b0;
    end else if (en) begin
      frac.valid <= valid;
    end
    if (en) begin
      frac.num <= num_next;
      frac.den <= den_next;
    end
  end

endmodule

@@ src/ttf_mul.sv @@
// ----------------------------------------------------------------------------
// ttf_mul
// Second stage: scales the numerator by the peak height.
// ----------------------------------------------------------------------------
module ttf_mul
  import ttf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ttf_frac_t         frac,
  input  logic [DATA_W-1:0] peak_height,
  output ttf_div_t          prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod.valid <= frac.valid;
    end
    if (en) begin
      prod.work <= PROD_W'(frac.num) * PROD_W'(peak_height);
      prod.den  <= frac.den;
    end
  end

endmodule

@@ src/ttf_div_stage.sv @@
// ----------------------------------------------------------------------------
// ttf_div_stage
// One restoring division stage that resolves DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module ttf_div_stage
  import ttf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  ttf_div_t din,
  output ttf_div_t dout
);

  logic [PROD_W-1:0] work_next;

  // The remainder always stays below the divisor, so a nine-bit trial
  // value covers every shift.
  always_comb begin
    logic [POS_W:0]   trial;
    logic [POS_W-1:0] rem;
    logic             qbit;
    work_next = din.work;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {work_next[PROD_W-1:LEVEL_W], work_next[LEVEL_W-1]};
      if (trial >= {1'b0, din.den}) begin
        rem  = POS_W'(trial - {1'b0, din.den});
        qbit = 1'b1;
      end else begin
        rem  = trial[POS_W-1:0];
        qbit = 1'b0;
      end
      work_next = {rem, work_next[LEVEL_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.work <= work_next;
      dout.den  <= din.den;
    end
  end

endmodule

@@ src/trapezoid_transfer_function.sv @@
// Throughput: one position per cycle while the level side takes its beats,
// set by the fully pipelined datapath: one classify stage, one multiply
// stage and four two-bit divider stages.
// A stalled level beat freezes the whole pipeline; nothing is dropped.
// Reset clears the five configuration registers to zero and empties the
// pipeline; it needs no clearing pass.
// ----------------------------------------------------------------------------
// trapezoid_transfer_function
// Evaluates a configurable trapezoid membership function at one position per
// beat and returns floor-rounded integer levels in order.
// ----------------------------------------------------------------------------
`include "trapezoid_transfer_function_assert.svh"

module trapezoid_transfer_function
  import ttf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  ttf_pos_if.sink              positions,
  ttf_level_if.source          levels,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]    wr_data
);

  // Configuration registers. Software writes them only while the pipeline is
  // empty, which the block itself does not enforce; every stage reads them directly.
  ttf_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (ttf_reg_t'(wr_index))
        REG_START:      cfg.start_pos      <= wr_data;
        REG_RISE_END:   cfg.rise_end_pos   <= wr_data;
        REG_FALL_START: cfg.fall_start_pos <= wr_data;
        REG_END:        cfg.end_pos        <= wr_data;
        REG_HEIGHT:     cfg.peak_height    <= wr_data;
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register is empty or
  // its beat is being taken. Because the output stage is the last of the
  // chain, a new position can still enter in the same cycle a result leaves.
  logic en;
  assign en = !levels.valid || levels.ready;
  assign positions.ready = en;

  ttf_frac_t frac;
  ttf_div_t  div_pipe [DIV_STAGES+1];

  // Stage one: region test and the edge fraction. Every case, including
  // outside and plateau, is turned into a fraction so the rest of the
  // pipeline needs no bypass path.
  ttf_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid    (positions.valid),
    .position (positions.position),
    .cfg      (cfg),
    .frac     (frac)
  );

  // Stage two: numerator times height, a 16-bit product.
  ttf_mul u_mul (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .frac        (frac),
    .peak_height (cfg.peak_height),
    .prod        (div_pipe[0])
  );

  // Stages three to six: restoring division. The quotient never exceeds
  // the height, so only the low eight quotient bits are computed and the
  // upper product byte is the starting remainder.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ttf_div_stage u_div (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (div_pipe[g]),
      .dout (div_pipe[g+1])
    );
  end

  // The last divider register doubles as the output register.
  assign levels.valid = div_pipe[DIV_STAGES].valid;
  assign levels.level = div_pipe[DIV_STAGES].work[LEVEL_W-1:0];

  // The division only works if the starting remainder is below the divisor.
  `TTF_ASSERT_NOW(a_div_precond, div_pipe[0].valid, div_pipe[0].work[PROD_W-1:LEVEL_W] < div_pipe[0].den)
  // A held result must block new positions, or the pipeline would overrun.
  `TTF_ASSERT_NOW(a_stall_blocks_input, levels.valid && !levels.ready, !positions.ready)
  // A held result must still be offered in the next cycle.
  `TTF_ASSERT_NEXT(a_stall_keeps_valid, levels.valid && !levels.ready, levels.valid)
  // Reset empties the pipeline.
  `TTF_ASSERT_AFTER_RESET(a_reset_empty, !levels.valid)

endmodule

@@ tb/tb_trapezoid_transfer_function.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trapezoid_transfer_function
// Self-checking bench for the trapezoid transfer function block. Positions
// are queued by a sequencer, driven by a handshake driver, and every level
// beat is checked against a local integer model of the trapezoid under
// changing corner and height settings and changing back-pressure.
// ----------------------------------------------------------------------------
module tb_trapezoid_transfer_function;
  import ttf_pkg::*;

  // The pipeline is six stages deep. Idle waits use a margin on top of that.
  localparam int PIPE_LATENCY   = 6;
  localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
  localparam int REG_COUNT      = 5;
  localparam int REG_SPACE      = 1 << REG_IDX_W;
  localparam int HOLD_CYCLES    = 48;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int MAX_REPORTS    = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [DATA_W-1:0]    wr_data = '0;

  ttf_pos_if   pos_if ();
  ttf_level_if lvl_if ();

  trapezoid_transfer_function i_dut (
    .clk      (clk),
    .rst      (rst),
    .positions(pos_if.sink),
    .levels   (lvl_if.source),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The shape as the block should see it, updated on each register write.
  ttf_cfg_t shape = '0;

  // Positions waiting to be offered, and levels owed by the block in order.
  logic [POS_W-1:0]   positions_to_send[$];
  logic [LEVEL_W-1:0] levels_due[$];

  // Set at a rising edge when the position beat on the bus was taken.
  logic pos_taken = 1'b0;

  // Idle percentages of the two sides; changed by the sequencer per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long receiver hold-offs: the sequencer asks, the receiver counts them out.
  int unsigned hold_requests = 0;
  int unsigned holds_started = 0;
  int unsigned hold_left     = 0;

  int unsigned mismatch_count = 0;
  int unsigned beats_checked  = 0;
  int unsigned settings_used  = 0;
  int unsigned idle_cycles    = 0;

  // Integer trapezoid: zero outside the feet, floor-divided ramps on the
  // edges, the height on the plateau. A degenerate edge gives the height.
  function automatic logic [LEVEL_W-1:0] trapezoid_level(input logic [POS_W-1:0] pos,
                                                         input ttf_cfg_t c);
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  span;
    logic [PROD_W-1:0] prod;
    if (pos > c.end_pos || pos < c.start_pos) return '0;
    if (pos < c.rise_end_pos) begin
      if (c.rise_end_pos <= c.start_pos) return c.peak_height;
      offset = pos - c.start_pos;
      span   = c.rise_end_pos - c.start_pos;
    end else if (pos > c.fall_start_pos) begin
      if (c.end_pos <= c.fall_start_pos) return c.peak_height;
      offset = c.end_pos - pos;
      span   = c.end_pos - c.fall_start_pos;
    end else begin
      return c.peak_height;
    end
    prod = PROD_W'(offset) * PROD_W'(c.peak_height);
    return LEVEL_W'(prod / PROD_W'(span));
  endfunction

  // Counts a failure and reports the first few of them.
  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Driver: changes the position channel at the falling edge. A raised valid
  // stays up, with its position, until the beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      pos_if.valid <= 1'b0;
    end else begin
      if (pos_taken) positions_to_send.delete(0);
      if (pos_if.valid && !pos_taken) begin
        // The offered beat is still waiting; leave it on the bus.
      end else if (positions_to_send.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        pos_if.valid    <= 1'b1;
        pos_if.position <= positions_to_send[0];
      end else begin
        pos_if.valid    <= 1'b0;
        pos_if.position <= POS_W'($urandom);
      end
    end
  end

  // Receiver: drives ready at the falling edge. A requested hold-off keeps
  // ready low for a fixed stretch, so the pipeline fills and stalls its input.
  always @(negedge clk) begin
    if (rst) begin
      lvl_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      lvl_if.ready <= 1'b0;
    end else if (holds_started != hold_requests) begin
      holds_started = holds_started + 1;
      hold_left = HOLD_CYCLES - 1;
      lvl_if.ready <= 1'b0;
    end else begin
      lvl_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: samples both channels and the write port at the rising edge.
  // An accepted position is predicted with the shape in force; an accepted
  // level is compared with the oldest prediction.
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    if (rst) begin
      pos_taken <= 1'b0;
    end else begin
      pos_taken <= pos_if.valid && pos_if.ready;
      if (pos_if.valid && pos_if.ready)
        levels_due.push_back(trapezoid_level(pos_if.position, shape));
      if (lvl_if.valid && lvl_if.ready) begin
        if (levels_due.size() == 0) begin
          flag_error($sformatf("level beat %0d with nothing expected", lvl_if.level));
        end else begin
          want = levels_due.pop_front();
          beats_checked++;
          if (lvl_if.level !== want)
            flag_error($sformatf("level mismatch: expected %0d, got %0d", want,
                                 lvl_if.level));
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_START:      shape.start_pos      <= wr_data;
          REG_RISE_END:   shape.rise_end_pos   <= wr_data;
          REG_FALL_START: shape.fall_start_pos <= wr_data;
          REG_END:        shape.end_pos        <= wr_data;
          REG_HEIGHT:     shape.peak_height    <= wr_data;
          default: begin
            // Indexes past the last register are ignored by the block.
          end
        endcase
      end
      // Watchdog: a stretch with no beat and no write means the block hung.
      if ((pos_if.valid && pos_if.ready) || (lvl_if.valid && lvl_if.ready) || wr_en)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d levels still owed",
                 WATCHDOG_LIMIT, levels_due.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // One register write, driven at the falling edge and held for one cycle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // Waits until every queued position has gone in and every level has come
  // out, then lets the pipeline settle. Writes are only made after this.
  task automatic wait_drained();
    while (positions_to_send.size() != 0 || pos_if.valid || levels_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Programs all five registers, sometimes followed by a write to an unused
  // index that must leave the shape alone.
  task automatic apply_shape(input ttf_cfg_t c);
    wait_drained();
    write_reg(REG_START,      c.start_pos);
    write_reg(REG_RISE_END,   c.rise_end_pos);
    write_reg(REG_FALL_START, c.fall_start_pos);
    write_reg(REG_END,        c.end_pos);
    write_reg(REG_HEIGHT,     c.peak_height);
    if ($urandom_range(3) == 0)
      write_reg(REG_IDX_W'($urandom_range(REG_SPACE - 1, REG_COUNT)), DATA_W'($urandom));
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_height();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 8'd1;
      2:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Mostly ordered corners, plus unordered, inverted, degenerate and extreme
  // shapes.
  function automatic ttf_cfg_t random_shape();
    ttf_cfg_t         c;
    int unsigned      corner[$];
    logic [POS_W-1:0] tmp;
    int unsigned      mode;
    mode = $urandom_range(9);
    corner = {};
    for (int k = 0; k < 4; k++) begin
      case (mode)
        7:       corner.push_back($urandom_range(1) ? 255 - $urandom_range(1)
                                                    : $urandom_range(1));
        9:       corner.push_back($urandom_range(255));
        default: corner.push_back($urandom_range(255));
      endcase
    end
    if (mode != 6 && mode != 8) corner.sort();
    if (mode == 9) begin
      // Collapse up to three corner gaps so ramps become vertical or the top a point.
      if ($urandom_range(1)) corner[1] = corner[0];
      if ($urandom_range(1)) corner[3] = corner[2];
      if ($urandom_range(1)) corner[2] = corner[1];
    end
    c.start_pos      = POS_W'(corner[0]);
    c.rise_end_pos   = POS_W'(corner[1]);
    c.fall_start_pos = POS_W'(corner[2]);
    c.end_pos        = POS_W'(corner[3]);
    if (mode == 8 && c.start_pos <= c.end_pos) begin
      // Feet swapped: nothing lies inside, unless both feet are equal.
      tmp         = c.start_pos;
      c.start_pos = c.end_pos;
      c.end_pos   = tmp;
    end
    c.peak_height = pick_height();
    return c;
  endfunction

  // Positions spread over the whole range, over the span between the
  // extreme corners, and at or right next to the corners.
  function automatic logic [POS_W-1:0] pick_position(input ttf_cfg_t c);
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    int unsigned      p;
    lo = c.start_pos;
    hi = c.start_pos;
    if (c.rise_end_pos < lo) lo = c.rise_end_pos;
    if (c.fall_start_pos < lo) lo = c.fall_start_pos;
    if (c.end_pos < lo) lo = c.end_pos;
    if (c.rise_end_pos > hi) hi = c.rise_end_pos;
    if (c.fall_start_pos > hi) hi = c.fall_start_pos;
    if (c.end_pos > hi) hi = c.end_pos;
    case ($urandom_range(4))
      0, 1: return POS_W'($urandom);
      2, 3: return POS_W'($urandom_range(32'(hi), 32'(lo)));
      default: begin
        case ($urandom_range(3))
          0:       p = 32'(c.start_pos);
          1:       p = 32'(c.rise_end_pos);
          2:       p = 32'(c.fall_start_pos);
          default: p = 32'(c.end_pos);
        endcase
        p = p + $urandom_range(2);
        if (p == 0) p = 1;
        p = p - 1;
        if (p > 255) p = 255;
        return POS_W'(p);
      end
    endcase
  endfunction

  // Sequencer: directed shapes first, then three phases of random shapes
  // and positions with different idle patterns on the two sides.
  initial begin
    ttf_cfg_t    c;
    int unsigned sent;
    int unsigned chunk;
    pos_if.valid    = 1'b0;
    pos_if.position = '0;
    lvl_if.ready    = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 69;

    // All registers at reset: a single point at zero with zero height.
    positions_to_send.push_back(8'd0);
    positions_to_send.push_back(8'd255);

    // An ordinary trapezoid at full height, probed at and around each corner.
    c = '{start_pos: 8'd10, rise_end_pos: 8'd50, fall_start_pos: 8'd100,
          end_pos: 8'd200, peak_height: 8'd255};
    apply_shape(c);
    for (int idx = REG_COUNT; idx < REG_SPACE; idx++)
      write_reg(REG_IDX_W'(idx), DATA_W'($urandom));
    @(posedge clk);
    positions_to_send.push_back(8'd0);
    positions_to_send.push_back(8'd9);
    positions_to_send.push_back(8'd10);
    positions_to_send.push_back(8'd11);
    positions_to_send.push_back(8'd30);
    positions_to_send.push_back(8'd49);
    positions_to_send.push_back(8'd50);
    positions_to_send.push_back(8'd75);
    positions_to_send.push_back(8'd100);
    positions_to_send.push_back(8'd101);
    positions_to_send.push_back(8'd150);
    positions_to_send.push_back(8'd199);
    positions_to_send.push_back(8'd200);
    positions_to_send.push_back(8'd201);
    positions_to_send.push_back(8'd255);

    // Start past the end: every position must give zero.
    c = '{start_pos: 8'd200, rise_end_pos: 8'd210, fall_start_pos: 8'd220,
          end_pos: 8'd100, peak_height: 8'd77};
    apply_shape(c);
    positions_to_send.push_back(8'd100);
    positions_to_send.push_back(8'd150);
    positions_to_send.push_back(8'd200);

    // Vertical edges over the full range: a flat top everywhere.
    c = '{start_pos: 8'd0, rise_end_pos: 8'd0, fall_start_pos: 8'd255,
          end_pos: 8'd255, peak_height: 8'd255};
    apply_shape(c);
    positions_to_send.push_back(8'd0);
    positions_to_send.push_back(8'd128);
    positions_to_send.push_back(8'd255);

    // Unordered corners: the tests apply in their fixed order.
    c = '{start_pos: 8'd100, rise_end_pos: 8'd20, fall_start_pos: 8'd240,
          end_pos: 8'd180, peak_height: 8'd200};
    apply_shape(c);
    positions_to_send.push_back(8'd50);
    positions_to_send.push_back(8'd150);
    positions_to_send.push_back(8'd190);

    // Random part in three idle phases.
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 20; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      chunk = 0;
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        c = random_shape();
        apply_shape(c);
        // In the first chunk of the sender-friendly phases, the receiver
        // holds off long enough to back the pipeline up into the input.
        if (chunk == 0 && phase != 1) hold_requests++;
        for (int n = $urandom_range(60, 20); n > 0; n--) begin
          positions_to_send.push_back(pick_position(c));
          sent++;
          // Once in a while the sender stops until every level is back.
          if (n == 10 && chunk == 1) begin
            wait_drained();
          end
        end
        chunk++;
      end
    end

    wait_drained();
    if (levels_due.size() != 0)
      flag_error($sformatf("%0d levels never arrived", levels_due.size()));

    $display("Summary: %0d level beats checked across %0d trapezoid settings,",
             beats_checked, settings_used);
    $display("  with inverted, unordered and collapsed shapes and both sides stalling.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d failures", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ttf_pkg.sv
src/ttf_pos_if.sv
src/ttf_level_if.sv
src/ttf_classify.sv
src/ttf_mul.sv
src/ttf_div_stage.sv
src/trapezoid_transfer_function.sv
tb/tb_trapezoid_transfer_function.sv
